[sv/rchs_pkg.sv]
// shared constants and types for the ray/cone hit select pipeline
// no dependencies
`default_nettype none
package rchs_pkg;

    localparam int RCHS_FRAC_BITS = 16;
    localparam int RCHS_CFG_IDX_W = 3;
    localparam int RCHS_SQRT_STAGES = 32;

    typedef enum logic [RCHS_CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_AXIS_X   = 3'd3,
        CFG_AXIS_Y   = 3'd4,
        CFG_AXIS_Z   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic             ok;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } side_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

[sv/rchs_sqrt.sv]
// pipelined integer square root, two radicand bits per stage
// depends on rchs_pkg
`default_nettype none
module rchs_sqrt
    import rchs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root
);

    localparam int N = RCHS_SQRT_STAGES;

    logic [63:0] val_reg  [N];
    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [63:0] val_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] tmp;
        logic [35:0] trial;
        logic        ge;
        logic [63:0] val_next;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (g == 0) begin : g_first
            assign val_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign val_in  = val_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        always_comb
        begin
            tmp       = {rem_in, val_in[63:62]};
            trial     = {2'b00, root_in, 2'b01};
            ge        = (tmp >= trial);
            rem_next  = ge ? 34'(tmp - trial) : tmp[33:0];
            root_next = {root_in[30:0], ge};
            val_next  = {val_in[61:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            val_reg[g]  <= val_next;
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
        end
    end

    assign root = root_reg[N-1];

endmodule
`default_nettype wire

[sv/rchs_div.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
// no dependencies
`default_nettype none
module rchs_div #(
    parameter int QW = 50,
    parameter int DW = 33
) (
    input  wire logic          clk,
    input  wire logic [QW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo
);

    logic [QW-1:0] num_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [QW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   tmp;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (g == 0) begin : g_first
            assign num_in = num;
            assign den_in = den;
            assign rem_in = '0;
            assign quo_in = '0;
        end else begin : g_rest
            assign num_in = num_reg[g-1];
            assign den_in = den_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin
            tmp      = {rem_in, num_in[QW-1]};
            ge       = (tmp >= {1'b0, den_in});
            rem_next = ge ? DW'(tmp - {1'b0, den_in}) : tmp[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            num_reg[g] <= {num_in[QW-2:0], 1'b0};
            den_reg[g] <= den_in;
            rem_reg[g] <= rem_next;
            quo_reg[g] <= {quo_in[QW-2:0], ge};
        end
    end

    assign quo = quo_reg[QW-1];

endmodule
`default_nettype wire

[sv/ray_cone_hit_select_top.sv]
// ray against cone: roots, hit points, side test and nearest-hit select
// throughput: one request per cycle, busy stays low; depth set by the
// sqrt pipeline (32 stages) and the root dividers (34 + FRAC_BITS stages)
// reset clears valid bits and cone registers; results cannot be held off
`default_nettype none
module ray_cone_hit_select_top
    import rchs_pkg::*;
#(
    parameter int FRAC_BITS = RCHS_FRAC_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      cfg_we,
    input  wire logic [RCHS_CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [31:0]               cfg_wdata,
    input  wire logic signed [31:0]        coef_a,
    input  wire logic signed [31:0]        coef_b,
    input  wire logic signed [31:0]        coef_c,
    input  wire logic signed [31:0]        ray_origin_x,
    input  wire logic signed [31:0]        ray_origin_y,
    input  wire logic signed [31:0]        ray_origin_z,
    input  wire logic signed [31:0]        ray_dir_x,
    input  wire logic signed [31:0]        ray_dir_y,
    input  wire logic signed [31:0]        ray_dir_z,
    output logic                           done,
    output logic                           hit,
    output logic signed [31:0]             hit_x,
    output logic signed [31:0]             hit_y,
    output logic signed [31:0]             hit_z,
    output logic signed [31:0]             root_first,
    output logic signed [31:0]             root_second
);

    localparam int QW   = 34 + FRAC_BITS;
    localparam int DW   = 33;
    localparam int SQ   = RCHS_SQRT_STAGES;
    localparam int DL   = SQ + QW + 1;
    localparam int DIVT = SQ + QW;

    logic [31:0] org_reg  [3];
    logic [31:0] axis_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                org_reg[i]  <= '0;
                axis_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_ORIGIN_X: org_reg[0]  <= cfg_wdata;
                CFG_ORIGIN_Y: org_reg[1]  <= cfg_wdata;
                CFG_ORIGIN_Z: org_reg[2]  <= cfg_wdata;
                CFG_AXIS_X:   axis_reg[0] <= cfg_wdata;
                CFG_AXIS_Y:   axis_reg[1] <= cfg_wdata;
                CFG_AXIS_Z:   axis_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits
    logic            v1_reg, v2_reg, v3_reg;
    logic [DL-1:0]   vdl_reg;
    logic            r1v_reg, r2v_reg, r3v_reg, r4v_reg, r5v_reg, r6v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vdl_reg <= '0;
            r1v_reg <= 1'b0;
            r2v_reg <= 1'b0;
            r3v_reg <= 1'b0;
            r4v_reg <= 1'b0;
            r5v_reg <= 1'b0;
            r6v_reg <= 1'b0;
        end else begin
            v1_reg  <= start && !busy;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vdl_reg <= {vdl_reg[DL-2:0], v3_reg};
            r1v_reg <= vdl_reg[DIVT];
            r2v_reg <= r1v_reg;
            r3v_reg <= r2v_reg;
            r4v_reg <= r3v_reg;
            r5v_reg <= r4v_reg;
            r6v_reg <= r5v_reg;
        end
    end

    // input capture
    side_t s1_reg;

    always_ff @(posedge clk)
    begin
        s1_reg.ok <= 1'b0;
        s1_reg.a  <= coef_a;
        s1_reg.b  <= coef_b;
        s1_reg.o  <= {ray_origin_z, ray_origin_y, ray_origin_x};
        s1_reg.d  <= {ray_dir_z, ray_dir_y, ray_dir_x};
    end

    logic [31:0] c1_reg;

    always_ff @(posedge clk)
    begin
        c1_reg <= coef_c;
    end

    // products for the discriminant
    side_t              s2_reg;
    logic signed [63:0] bb_reg, ac_reg;

    always_ff @(posedge clk)
    begin
        s2_reg <= s1_reg;
        bb_reg <= $signed(s1_reg.b) * $signed(s1_reg.b);
        ac_reg <= $signed(s1_reg.a) * $signed(c1_reg);
    end

    // discriminant
    side_t              s3_reg, s3_next;
    logic [63:0]        rad_reg;
    logic signed [63:0] e_next;
    logic               ok_next;

    always_comb
    begin
        e_next     = (bb_reg >>> 2) - ac_reg;
        ok_next    = (s2_reg.a != '0) && !e_next[63];
        s3_next    = s2_reg;
        s3_next.ok = ok_next;
    end

    always_ff @(posedge clk)
    begin
        s3_reg  <= s3_next;
        rad_reg <= ok_next ? e_next : '0;
    end

    logic [31:0] sq_root;

    rchs_sqrt u_sqrt (
        .clk      (clk),
        .radicand (rad_reg),
        .root     (sq_root)
    );

    side_t dl_reg [DL];

    always_ff @(posedge clk)
    begin
        dl_reg[0] <= s3_reg;
        for (int k = 1; k < DL; k++)
            dl_reg[k] <= dl_reg[k-1];
    end

    // numerators and divisor magnitudes
    logic signed [34:0] num0_next, num1_next, b35, s35;
    logic [33:0]        mag0_next, mag1_next;
    logic [31:0]        abs_a;
    logic [QW-1:0]      mag0_reg, mag1_reg;
    logic [DW-1:0]      den_reg;
    logic [1:0]         neg_reg [QW+1];
    logic [31:0]        tap_a;

    always_comb
    begin
        tap_a     = dl_reg[SQ-1].a;
        b35       = 35'($signed(dl_reg[SQ-1].b));
        s35       = $signed({2'b00, sq_root, 1'b0});
        num0_next = s35 - b35;
        num1_next = -b35 - s35;
        mag0_next = num0_next[34] ? 34'(-num0_next) : num0_next[33:0];
        mag1_next = num1_next[34] ? 34'(-num1_next) : num1_next[33:0];
        abs_a     = tap_a[31] ? 32'(-tap_a) : tap_a;
    end

    always_ff @(posedge clk)
    begin
        mag0_reg   <= {mag0_next, {FRAC_BITS{1'b0}}};
        mag1_reg   <= {mag1_next, {FRAC_BITS{1'b0}}};
        den_reg    <= {abs_a, 1'b0};
        neg_reg[0] <= {num1_next[34] ^ tap_a[31], num0_next[34] ^ tap_a[31]};
        for (int k = 1; k <= QW; k++)
            neg_reg[k] <= neg_reg[k-1];
    end

    logic [QW-1:0] quo0, quo1;

    rchs_div #(.QW(QW), .DW(DW)) u_div0 (
        .clk (clk),
        .num (mag0_reg),
        .den (den_reg),
        .quo (quo0)
    );

    rchs_div #(.QW(QW), .DW(DW)) u_div1 (
        .clk (clk),
        .num (mag1_reg),
        .den (den_reg),
        .quo (quo1)
    );

    function automatic logic signed [31:0] sat_quo(input logic [QW-1:0] q, input logic neg);
        if (neg)
            return (q > QW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : 32'(-q[31:0]);
        else
            return (q > QW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(q[31:0]);
    endfunction

    // root saturation and negative replacement
    logic signed [31:0] t0_next, t1_next, q0s, q1s, t1r;
    side_t              tap_s;
    logic signed [31:0] r1t0_reg, r1t1_reg;
    logic               r1ok_reg;
    logic [2:0][31:0]   r1o_reg, r1d_reg;

    always_comb
    begin
        tap_s = dl_reg[DIVT];
        q0s   = sat_quo(quo0, neg_reg[QW][0]);
        q1s   = sat_quo(quo1, neg_reg[QW][1]);
        t1r   = q1s[31] ? q0s : q1s;
        t0_next = q0s[31] ? t1r : q0s;
        t1_next = t1r;
        if (!tap_s.ok) begin
            t0_next = '0;
            t1_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        r1t0_reg <= t0_next;
        r1t1_reg <= t1_next;
        r1ok_reg <= tap_s.ok;
        r1o_reg  <= tap_s.o;
        r1d_reg  <= tap_s.d;
    end

    // t * d
    logic signed [63:0] r2p0_reg [3];
    logic signed [63:0] r2p1_reg [3];
    logic signed [31:0] r2t0_reg, r2t1_reg;
    logic               r2ok_reg;
    logic [2:0][31:0]   r2o_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            r2p0_reg[i] <= r1t0_reg * $signed(r1d_reg[i]);
            r2p1_reg[i] <= r1t1_reg * $signed(r1d_reg[i]);
        end
        r2t0_reg <= r1t0_reg;
        r2t1_reg <= r1t1_reg;
        r2ok_reg <= r1ok_reg;
        r2o_reg  <= r1o_reg;
    end

    // hit points
    logic [31:0]        r3pt0_reg [3];
    logic [31:0]        r3pt1_reg [3];
    logic signed [31:0] r3t0_reg, r3t1_reg;
    logic               r3ok_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            r3pt0_reg[i] <= sat32(64'($signed(r2o_reg[i])) + (r2p0_reg[i] >>> FRAC_BITS));
            r3pt1_reg[i] <= sat32(64'($signed(r2o_reg[i])) + (r2p1_reg[i] >>> FRAC_BITS));
        end
        r3t0_reg <= r2t0_reg;
        r3t1_reg <= r2t1_reg;
        r3ok_reg <= r2ok_reg;
    end

    // offset times axis
    logic signed [64:0] r4m0_reg [3];
    logic signed [64:0] r4m1_reg [3];
    logic [31:0]        r4pt0_reg [3];
    logic [31:0]        r4pt1_reg [3];
    logic signed [31:0] r4t0_reg, r4t1_reg;
    logic               r4ok_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            r4m0_reg[i] <= (33'($signed(r3pt0_reg[i])) - 33'($signed(org_reg[i])))
                           * $signed(axis_reg[i]);
            r4m1_reg[i] <= (33'($signed(r3pt1_reg[i])) - 33'($signed(org_reg[i])))
                           * $signed(axis_reg[i]);
            r4pt0_reg[i] <= r3pt0_reg[i];
            r4pt1_reg[i] <= r3pt1_reg[i];
        end
        r4t0_reg <= r3t0_reg;
        r4t1_reg <= r3t1_reg;
        r4ok_reg <= r3ok_reg;
    end

    // side test
    logic signed [66:0] dot0_next, dot1_next;
    logic               r5b0_reg, r5b1_reg;
    logic [31:0]        r5pt0_reg [3];
    logic [31:0]        r5pt1_reg [3];
    logic signed [31:0] r5t0_reg, r5t1_reg;
    logic               r5ok_reg;

    always_comb
    begin
        dot0_next = 67'(r4m0_reg[0]) + 67'(r4m0_reg[1]) + 67'(r4m0_reg[2]);
        dot1_next = 67'(r4m1_reg[0]) + 67'(r4m1_reg[1]) + 67'(r4m1_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        r5b0_reg  <= dot0_next[66];
        r5b1_reg  <= dot1_next[66];
        r5pt0_reg <= r4pt0_reg;
        r5pt1_reg <= r4pt1_reg;
        r5t0_reg  <= r4t0_reg;
        r5t1_reg  <= r4t1_reg;
        r5ok_reg  <= r4ok_reg;
    end

    // nearest passing hit
    logic        sel_hit, sel_p1;
    logic [31:0] hx_reg, hy_reg, hz_reg, rf_reg, rs_reg;
    logic        hit_reg;

    always_comb
    begin
        sel_hit = 1'b0;
        sel_p1  = 1'b0;
        if (r5t0_reg == r5t1_reg) begin
            sel_hit = r5b0_reg;
        end else if (r5t0_reg < r5t1_reg) begin
            sel_hit = r5b0_reg || r5b1_reg;
            sel_p1  = !r5b0_reg;
        end else begin
            sel_hit = r5b0_reg || r5b1_reg;
            sel_p1  = r5b1_reg;
        end
        sel_hit = sel_hit && r5ok_reg;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= sel_hit;
        hx_reg  <= !sel_hit ? '0 : (sel_p1 ? r5pt1_reg[0] : r5pt0_reg[0]);
        hy_reg  <= !sel_hit ? '0 : (sel_p1 ? r5pt1_reg[1] : r5pt0_reg[1]);
        hz_reg  <= !sel_hit ? '0 : (sel_p1 ? r5pt1_reg[2] : r5pt0_reg[2]);
        rf_reg  <= r5t0_reg;
        rs_reg  <= r5t1_reg;
    end

    assign done        = r6v_reg;
    assign hit         = hit_reg;
    assign hit_x       = $signed(hx_reg);
    assign hit_y       = $signed(hy_reg);
    assign hit_z       = $signed(hz_reg);
    assign root_first  = $signed(rf_reg);
    assign root_second = $signed(rs_reg);

endmodule
`default_nettype wire

[sv/rchs_checker.sv]
// port-level checks for ray_cone_hit_select_top, bound to the top level
// depends on rchs_pkg and ray_cone_hit_select_top
`default_nettype none
module rchs_checker
    import rchs_pkg::*;
#(
    parameter int FRAC_BITS = RCHS_FRAC_BITS
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        hit,
    input wire logic [31:0] hit_x,
    input wire logic [31:0] hit_y,
    input wire logic [31:0] hit_z,
    input wire logic [31:0] root_first,
    input wire logic [31:0] root_second
);

    localparam int LAT = 76 + FRAC_BITS;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (hit_x == '0) && (hit_y == '0) && (hit_z == '0))
        else $error("miss carries a point");

    a_neg_roots_equal: assert property (@(posedge clk) disable iff (!rst_n)
        done && (root_first[31] || root_second[31]) |-> root_first == root_second)
        else $error("negative root not replaced");

endmodule

bind ray_cone_hit_select_top rchs_checker #(.FRAC_BITS(FRAC_BITS)) u_rchs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .hit_x       (hit_x),
    .hit_y       (hit_y),
    .hit_z       (hit_z),
    .root_first  (root_first),
    .root_second (root_second)
);
`default_nettype wire

[verif/ray_cone_hit_select_top_test.sv]
// testbench for ray_cone_hit_select_top: directed and random rays against a configurable cone
// depends on rchs_pkg and ray_cone_hit_select_top; predicts each result and compares on done
`default_nettype none
module ray_cone_hit_select_top_test;
    import rchs_pkg::*;

    localparam int FB = RCHS_FRAC_BITS;
    localparam int LATENCY = 76 + FB;

    typedef struct {
        logic signed [31:0] a, b, c;
        logic signed [31:0] o [3];
        logic signed [31:0] d [3];
    } ray_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] p [3];
        logic signed [31:0] t0, t1;
    } hit_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic cfg_we = 0;
    logic [RCHS_CFG_IDX_W-1:0] cfg_idx = CFG_ORIGIN_X;
    logic [31:0] cfg_wdata = 0;
    logic signed [31:0] coef_a = 0, coef_b = 0, coef_c = 0;
    logic signed [31:0] ray_origin_x = 0, ray_origin_y = 0, ray_origin_z = 0;
    logic signed [31:0] ray_dir_x = 0, ray_dir_y = 0, ray_dir_z = 0;
    logic done, hit;
    logic signed [31:0] hit_x, hit_y, hit_z, root_first, root_second;

    ray_cone_hit_select_top dut (.*);

    logic signed [31:0] cone_org [3];
    logic signed [31:0] cone_axis [3];
    hit_t expected_hits [$];
    int errors = 0;
    int idle_pct = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("ray_cone_hit_select_top verification failed");
        $finish;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned r = 0, bt = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic bit behind(logic signed [31:0] p [3]);
        logic signed [127:0] acc = 0;
        for (int i = 0; i < 3; i++)
            acc += (128'(signed'(p[i])) - 128'(signed'(cone_org[i])))
                   * 128'(signed'(cone_axis[i]));
        return acc < 0;
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        hit_t h;
        longint a, b, c, e, s, t0, t1;
        logic signed [31:0] p0 [3], p1 [3];
        bit ok0, ok1;
        h.hit = 0;
        h.t0 = 0;
        h.t1 = 0;
        for (int i = 0; i < 3; i++)
            h.p[i] = 0;
        a = longint'(r.a);
        b = longint'(r.b);
        c = longint'(r.c);
        e = ((b * b) >>> 2) - a * c;
        if (a == 0 || e < 0)
            return h;
        s = 2 * root64(e);
        t0 = clamp32(((s - b) * (64'sd1 << FB)) / (2 * a));
        t1 = clamp32(((-b - s) * (64'sd1 << FB)) / (2 * a));
        if (t1 < 0)
            t1 = t0;
        if (t0 < 0)
            t0 = t1;
        for (int i = 0; i < 3; i++)
        begin
            p0[i] = 32'(clamp32(longint'(r.o[i]) + ((t0 * longint'(r.d[i])) >>> FB)));
            p1[i] = 32'(clamp32(longint'(r.o[i]) + ((t1 * longint'(r.d[i])) >>> FB)));
        end
        ok0 = behind(p0);
        ok1 = behind(p1);
        h.t0 = 32'(t0);
        h.t1 = 32'(t1);
        if (t0 <= t1 ? ok0 : (!ok1 && ok0))
        begin
            h.hit = 1;
            h.p = p0;
        end
        else if (t0 != t1 && ok1)
        begin
            h.hit = 1;
            h.p = p1;
        end
        return h;
    endfunction

    always @(posedge clk)
    begin
        hit_t x;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result hit=%0d", $time, hit);
            end
            else
            begin
                x = expected_hits.pop_front();
                if (hit !== x.hit)
                begin
                    errors++;
                    $display("%0t: hit exp %0d got %0d", $time, x.hit, hit);
                end
                if (hit_x !== x.p[0] || hit_y !== x.p[1] || hit_z !== x.p[2])
                begin
                    errors++;
                    $display("%0t: point exp %0d %0d %0d got %0d %0d %0d", $time,
                             x.p[0], x.p[1], x.p[2], hit_x, hit_y, hit_z);
                end
                if (root_first !== x.t0)
                begin
                    errors++;
                    $display("%0t: root_first exp %0d got %0d", $time, x.t0, root_first);
                end
                if (root_second !== x.t1)
                begin
                    errors++;
                    $display("%0t: root_second exp %0d got %0d", $time, x.t1, root_second);
                end
            end
        end
    end

    task automatic send_ray(ray_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        coef_a <= r.a;
        coef_b <= r.b;
        coef_c <= r.c;
        ray_origin_x <= r.o[0];
        ray_origin_y <= r.o[1];
        ray_origin_z <= r.o[2];
        ray_dir_x <= r.d[0];
        ray_dir_y <= r.d[1];
        ray_dir_z <= r.d[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_hits.push_back(predict_hit(r));
    endtask

    task automatic drain_requests();
        start <= 0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_cone(cfg_idx_t idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= v;
        if (idx <= CFG_ORIGIN_Z)
            cone_org[idx] = v;
        else
            cone_axis[idx - CFG_AXIS_X] = v;
        @(posedge clk);
    endtask

    task automatic set_cone(logic [31:0] ox, oy, oz, ax, ay, az);
        write_cone(CFG_ORIGIN_X, ox);
        write_cone(CFG_ORIGIN_Y, oy);
        write_cone(CFG_ORIGIN_Z, oz);
        write_cone(CFG_AXIS_X, ax);
        write_cone(CFG_AXIS_Y, ay);
        write_cone(CFG_AXIS_Z, az);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'($signed($urandom_range(16'hffff)) - 32768);
            default: return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        r.a = rand_word();
        r.b = rand_word();
        r.c = rand_word();
        if ($urandom_range(3) != 0)
        begin
            // keep the discriminant mostly non-negative so roots form
            r.a = 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
            r.c = -32'($signed($urandom_range(32'h0004_0000))) * (r.a < 0 ? -1 : 1);
        end
        if (r.a == 0 && $urandom_range(9) != 0)
            r.a = 32'h0001_0000;
        for (int i = 0; i < 3; i++)
        begin
            r.o[i] = rand_word();
            r.d[i] = rand_word();
        end
        return r;
    endfunction

    function automatic ray_t make_ray(int a, b, c, ox, oy, oz, dx, dy, dz);
        ray_t r;
        r.a = a;
        r.b = b;
        r.c = c;
        r.o = '{ox, oy, oz};
        r.d = '{dx, dy, dz};
        return r;
    endfunction

    task automatic test_directed();
        localparam int ONE = 32'h0001_0000;
        send_ray(make_ray(0, ONE, ONE, 0, 0, 0, ONE, 0, 0));
        send_ray(make_ray(ONE, 0, ONE, 0, 0, 0, ONE, 0, 0));
        send_ray(make_ray(ONE, -4 * ONE, 3 * ONE, 0, 0, 0, 0, 0, -ONE));
        send_ray(make_ray(ONE, -4 * ONE, 3 * ONE, 0, 0, 0, 0, 0, ONE));
        send_ray(make_ray(ONE, 4 * ONE, 3 * ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        send_ray(make_ray(ONE, 2 * ONE, ONE, 0, 0, 0, ONE, 0, 0));
        send_ray(make_ray(ONE, 0, -ONE, 0, 0, 0, 0, 0, -ONE));
        send_ray(make_ray(-ONE, 0, ONE, 5, 5, 5, -ONE, ONE, -ONE));
        send_ray(make_ray(1, 32'h7fff_ffff, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0));
        send_ray(make_ray(1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000, -1));
        send_ray(make_ray(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          -1, -1, -1, -1, -1, -1));
        send_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_ray(make_ray(ONE, -3 * ONE, 2 * ONE, 0, 0, 10 * ONE, 0, 0, -ONE));
    endtask

    task automatic test_random(int n, int pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++)
            send_ray(rand_ray());
    endtask

    initial
    begin
        cone_org = '{0, 0, 0};
        cone_axis = '{0, 0, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        drain_requests();
        set_cone(0, 0, 0, 0, 0, 32'h0001_0000);
        test_directed();
        drain_requests();
        set_cone(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        test_random(60, 31);
        // hold off until every request has returned
        drain_requests();
        set_cone($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        test_random(130, 71);
        drain_requests();
        set_cone(32'h0002_0000, 32'hffff_0000, 0, 32'h0001_0000, 32'hffff_8000,
                 32'h0000_4000);
        test_random(180, 0);
        drain_requests();
        if (errors == 0)
            $display("ray_cone_hit_select_top verification clean");
        else
            $display("ray_cone_hit_select_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
sv/rchs_pkg.sv
sv/rchs_sqrt.sv
sv/rchs_div.sv
sv/ray_cone_hit_select_top.sv
sv/rchs_checker.sv
verif/ray_cone_hit_select_top_test.sv
